FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CHK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CHK(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)
`endif

`endif

FILE: hw/rtl/pcbd_pkg.sv
package pcbd_pkg;

   localparam int TABLE_SLOTS = 8;
   localparam int IDX_W       = 3;
   localparam int ENTRY_W     = 29;
   localparam int CODE_W      = 16;
   localparam int ELEN_LSB    = 16;
   localparam int ELEN_W      = 5;
   localparam int SYM_LSB     = 21;
   localparam int SYM_W       = 8;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;

   typedef logic [ENTRY_W-1:0] entry_type;
   typedef entry_type [TABLE_SLOTS-1:0] entry_array_type;

   typedef struct packed {
      logic             symbol_valid;
      logic [SYM_W-1:0] symbol;
      logic             lost;
   } rsp_type;

endpackage

FILE: hw/rtl/pcbd_regs.sv
module pcbd_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pcbd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [pcbd_pkg::DATA_W-1:0] csr_pwdata,
   output logic [pcbd_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output pcbd_pkg::entry_array_type   entries
);
   import pcbd_pkg::*;

   entry_array_type   entry_ff;
   entry_array_type   entry_in;
   logic [IDX_W-1:0]  reg_idx;
   logic              wr_en;

   assign reg_idx    = csr_paddr[ADDR_W-1:ADDR_W-IDX_W];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = DATA_W'(entry_ff[reg_idx]);
   assign entries    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (wr_en) begin
         entry_in[reg_idx] = csr_pwdata[ENTRY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

FILE: hw/rtl/pcbd_step.sv
module pcbd_step #(
   parameter int NUM_ENTRIES  = 8,
   parameter int MAX_CODE_LEN = 16,
   parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
   input  pcbd_pkg::entry_array_type entries,
   input  logic [MAX_CODE_LEN-1:0]   pend_bits,
   input  logic [LEN_W-1:0]          pend_len,
   input  logic                      lost,
   input  logic                      code_bit,
   input  logic                      message_start,
   output logic [MAX_CODE_LEN-1:0]   pend_bits_next,
   output logic [LEN_W-1:0]          pend_len_next,
   output logic                      lost_next,
   output pcbd_pkg::rsp_type         result
);
   import pcbd_pkg::*;

   logic [MAX_CODE_LEN-1:0] bits0;
   logic [LEN_W-1:0]        len0;
   logic                    lost0;
   logic [MAX_CODE_LEN:0]   shifted;
   logic [MAX_CODE_LEN-1:0] new_bits;
   logic [LEN_W-1:0]        new_len;
   logic [MAX_CODE_LEN-1:0] mask;
   logic                    hit;
   logic [SYM_W-1:0]        hit_sym;

   assign bits0    = message_start ? '0 : pend_bits;
   assign len0     = message_start ? '0 : pend_len;
   assign lost0    = message_start ? 1'b0 : lost;
   assign shifted  = {bits0, code_bit};
   assign new_bits = shifted[MAX_CODE_LEN-1:0];
   assign new_len  = len0 + LEN_W'(1);

   always_comb begin
      for (int j = 0; j < MAX_CODE_LEN; j++) begin
         mask[j] = (LEN_W'(j) < new_len);
      end
   end

   // lowest index wins: scan downward so the last hit assigned is the lowest
   always_comb begin
      hit     = 1'b0;
      hit_sym = '0;
      for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
         if (entries[i][ELEN_LSB +: ELEN_W] == ELEN_W'(new_len) &&
             ((entries[i][MAX_CODE_LEN-1:0] ^ new_bits) & mask) == '0) begin
            hit     = 1'b1;
            hit_sym = entries[i][SYM_LSB +: SYM_W];
         end
      end
   end

   always_comb begin
      pend_bits_next      = bits0;
      pend_len_next       = len0;
      lost_next           = lost0;
      result.symbol_valid = 1'b0;
      result.symbol       = '0;
      if (!lost0) begin
         if (len0 == LEN_W'(MAX_CODE_LEN)) begin
            lost_next      = 1'b1;
            pend_bits_next = '0;
            pend_len_next  = '0;
         end else if (hit) begin
            pend_bits_next      = '0;
            pend_len_next       = '0;
            result.symbol_valid = 1'b1;
            result.symbol       = hit_sym;
         end else begin
            pend_bits_next = new_bits;
            pend_len_next  = new_len;
         end
      end
      result.lost = lost_next;
   end

endmodule

FILE: hw/rtl/prefix_code_bit_decoder_unit.sv
// Prefix code bit decoder.
// Code bits arrive one per item on the req_ channel (req_code_bit, plus
// req_message_start to begin a new message). Each accepted item yields
// exactly one result item on the rsp_ channel: symbol_valid, symbol, lost.
// The codeword table is eight registers on the csr_ APB port at 4*i;
// write them only while no items are in flight.
// A result is registered into the output buffer when its item is accepted.
// Throughput: one item per cycle while req_stall is low; all table entries are compared in
// parallel in one step between the decoder state and the output buffer.
// The output side is a two-entry buffer: an item is still accepted while
// one result waits under rsp_stall; req_stall rises only while the second
// buffer entry is occupied, and clears once the receiver takes a result.
// Reset clears the table (all entries unused), the accumulator, the lost
// flag and both buffer entries.
`include "assert_macros.svh"

module prefix_code_bit_decoder_unit #(
   parameter int NUM_ENTRIES  = 8,
   parameter int MAX_CODE_LEN = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_code_bit,
   input  logic                        req_message_start,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_symbol_valid,
   output logic [pcbd_pkg::SYM_W-1:0]  rsp_symbol,
   output logic                        rsp_lost,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pcbd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [pcbd_pkg::DATA_W-1:0] csr_pwdata,
   output logic [pcbd_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);
   import pcbd_pkg::*;

   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

   entry_array_type         entries;
   logic [MAX_CODE_LEN-1:0] pend_bits_ff, pend_bits_in;
   logic [LEN_W-1:0]        pend_len_ff, pend_len_in;
   logic                    lost_ff, lost_in;
   rsp_type                 step_rsp;
   rsp_type                 main_ff, main_in;
   rsp_type                 skid_ff, skid_in;
   logic                    main_valid_ff, main_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   logic                    accept;
   logic                    main_free;

   pcbd_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .entries     (entries)
   );

   pcbd_step #(
      .NUM_ENTRIES  (NUM_ENTRIES),
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .LEN_W        (LEN_W)
   ) u_step (
      .entries        (entries),
      .pend_bits      (pend_bits_ff),
      .pend_len       (pend_len_ff),
      .lost           (lost_ff),
      .code_bit       (req_code_bit),
      .message_start  (req_message_start),
      .pend_bits_next (pend_bits_in),
      .pend_len_next  (pend_len_in),
      .lost_next      (lost_in),
      .result         (step_rsp)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign main_free = !main_valid_ff || !rsp_stall;

   assign rsp_valid        = main_valid_ff;
   assign rsp_symbol_valid = main_ff.symbol_valid;
   assign rsp_symbol       = main_ff.symbol;
   assign rsp_lost         = main_ff.lost;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = step_rsp;
            main_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = step_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff  <= '0;
         pend_len_ff   <= '0;
         lost_ff       <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pend_bits_ff <= pend_bits_in;
            pend_len_ff  <= pend_len_in;
            lost_ff      <= lost_in;
         end
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `ASSERT_CHK(a_skid_needs_main, clock, reset, skid_valid_ff |-> main_valid_ff)
   `ASSERT_NEVER(a_sym_while_lost, clock, reset, rsp_valid && rsp_symbol_valid && rsp_lost)
   `ASSERT_CHK(a_sym_zero, clock, reset, (rsp_valid && !rsp_symbol_valid) |-> (rsp_symbol == '0))
   `ASSERT_CHK(a_len_bound, clock, reset, pend_len_ff <= LEN_W'(MAX_CODE_LEN))
   `ASSERT_CHK(a_lost_empty, clock, reset, lost_ff |-> (pend_len_ff == '0 && pend_bits_ff == '0))

endmodule
